// ===== src/fbwc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbwc_pkg
// Shared constants and command codes for the flash block write-back cache.
// ----------------------------------------------------------------------------
package fbwc_pkg;

  localparam int BLOCK_BYTES  = 4096;
  localparam int SECTOR_BYTES = 512;
  localparam int MAX_SECTORS  = 64;
  localparam int MAX_RESULTS  = 40;

  localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int LEN_W        = 16;
  localparam int CHUNK_W      = 13;
  localparam int NOUT_W       = 6;

  localparam logic [31:0] VOLUME_BASE_RESET = 32'h0180_0000;

  typedef logic [2:0] action_t;

  localparam action_t ACT_F2H        = 3'd0;
  localparam action_t ACT_C2H        = 3'd1;
  localparam action_t ACT_ERASE      = 3'd2;
  localparam action_t ACT_PROG_CACHE = 3'd3;
  localparam action_t ACT_PROG_HOST  = 3'd4;
  localparam action_t ACT_LOAD       = 3'd5;
  localparam action_t ACT_H2C        = 3'd6;
  localparam action_t ACT_DONE       = 3'd7;

  localparam logic [2:0] MODE_READ  = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_SYNC  = 3'd2;
  localparam logic [2:0] MODE_MOUNT = 3'd3;
  localparam logic [2:0] MODE_TRIM  = 3'd4;

endpackage

// ===== src/flash_block_writeback_cache.sv =====
// Sequence: an accepted request that walks a chunk is registered in S_CHUNK before
// its first command (one with no chunk goes straight to its flush or done item); then
// one command per cycle unless output stalls; each block chunk revisits S_CHUNK.
// Flow: one request at a time, paced by the single chunk sequencer; in_ready
// stays low until the done item is issued.
// Reset: synchronous; cache invalid and clean, block tag all ones, base 0x01800000.
// ----------------------------------------------------------------------------
// flash_block_writeback_cache
// Splits sector requests into erase-block chunks and issues flash and cache
// transfer commands for a one-entry write-back block cache (sync flushes a dirty block), then a done item.
// ----------------------------------------------------------------------------
module flash_block_writeback_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] volume_base,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [7:0]  drive,
  input  logic [13:0] sector,
  input  logic [6:0]  count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [31:0] flash_addr,
  output logic [14:0] host_offset,
  output logic [11:0] cache_offset,
  output logic [12:0] length,
  output logic        status,
  output logic        last
);

  localparam int BS  = fbwc_pkg::BLOCK_SHIFT;
  localparam int LW  = fbwc_pkg::LEN_W;
  localparam int CW  = fbwc_pkg::CHUNK_W;
  localparam int NW  = fbwc_pkg::NOUT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHUNK = 4'd1;
  localparam logic [3:0] S_FE    = 4'd2;
  localparam logic [3:0] S_FP    = 4'd3;
  localparam logic [3:0] S_ER    = 4'd4;
  localparam logic [3:0] S_PH    = 4'd5;
  localparam logic [3:0] S_LD    = 4'd6;
  localparam logic [3:0] S_H2C   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [CW-1:0] BLK_LEN = CW'(fbwc_pkg::BLOCK_BYTES);

  logic [3:0]    state;
  logic [3:0]    after_flush;
  logic [31:0]   vbase;
  logic [31:0]   cached_blk;
  logic          cache_valid;
  logic          cache_dirty;
  logic [31:0]   base_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] off_r;
  logic          wr_r;
  logic          req_status;
  logic [31:0]   a_r;
  logic [BS-1:0] boff_r;
  logic [CW-1:0] chunk_r;
  logic          hit_r;
  logic [NW-1:0] n_out;

  logic [31:0]   a_c;
  logic [BS-1:0] boff_c;
  logic [31:0]   blk_c;
  logic [CW-1:0] room_c;
  logic [CW-1:0] chunk_c;
  logic          hit_c;
  logic          full_c;
  logic          flush_c;
  logic [31:0]   blk_r;

  logic          emit;
  logic          go;
  logic          keep;
  logic          cmd_last;
  fbwc_pkg::action_t cmd_act;
  logic [31:0]   cmd_addr;
  logic [14:0]   cmd_host;
  logic [11:0]   cmd_cache;
  logic [12:0]   cmd_len;
  logic [3:0]    adv_state;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  assign a_c     = base_r + {{(32-LW){1'b0}}, off_r};
  assign boff_c  = a_c[BS-1:0];
  assign blk_c   = {a_c[31:BS], {BS{1'b0}}};
  assign room_c  = BLK_LEN - {{(CW-BS){1'b0}}, boff_c};
  assign chunk_c = (len_r < {{(LW-CW){1'b0}}, room_c}) ? len_r[CW-1:0] : room_c;
  assign hit_c   = cache_valid && (cached_blk == blk_c);
  assign full_c  = (boff_c == '0) && (chunk_c == BLK_LEN);
  assign flush_c = cache_valid && cache_dirty;
  assign blk_r   = {a_r[31:BS], {BS{1'b0}}};

  assign go        = emit && (!out_valid || out_ready);
  assign keep      = cmd_last || (n_out < NW'(fbwc_pkg::MAX_RESULTS - 1));
  assign adv_state = (len_r == {{(LW-CW){1'b0}}, chunk_r}) ? S_DONE : S_CHUNK;

  always_comb begin
    emit      = 1'b0;
    cmd_last  = 1'b0;
    cmd_act   = fbwc_pkg::ACT_DONE;
    cmd_addr  = '0;
    cmd_host  = '0;
    cmd_cache = '0;
    cmd_len   = '0;
    case (state)
      S_FE, S_FP: begin
        emit     = 1'b1;
        cmd_act  = (state == S_FE) ? fbwc_pkg::ACT_ERASE : fbwc_pkg::ACT_PROG_CACHE;
        cmd_addr = cached_blk;
        cmd_len  = BLK_LEN;
      end
      S_ER, S_LD: begin
        emit     = 1'b1;
        cmd_act  = (state == S_ER) ? fbwc_pkg::ACT_ERASE : fbwc_pkg::ACT_LOAD;
        cmd_addr = blk_r;
        cmd_len  = BLK_LEN;
      end
      S_PH: begin
        emit     = 1'b1;
        cmd_act  = fbwc_pkg::ACT_PROG_HOST;
        cmd_addr = blk_r;
        cmd_host = off_r[14:0];
        cmd_len  = chunk_r;
      end
      S_H2C: begin
        emit      = 1'b1;
        cmd_act   = fbwc_pkg::ACT_H2C;
        cmd_addr  = a_r;
        cmd_host  = off_r[14:0];
        cmd_cache = boff_r;
        cmd_len   = chunk_r;
      end
      S_RD: begin
        emit      = 1'b1;
        cmd_act   = hit_r ? fbwc_pkg::ACT_C2H : fbwc_pkg::ACT_F2H;
        cmd_addr  = a_r;
        cmd_host  = off_r[14:0];
        cmd_cache = hit_r ? boff_r : '0;
        cmd_len   = chunk_r;
      end
      S_DONE: begin
        emit     = 1'b1;
        cmd_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      after_flush <= S_DONE;
      vbase       <= fbwc_pkg::VOLUME_BASE_RESET;
      cached_blk  <= '1;
      cache_valid <= 1'b0;
      cache_dirty <= 1'b0;
      out_valid   <= 1'b0;
      n_out       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vbase <= volume_base;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (go && keep) begin
        out_valid    <= 1'b1;
        action       <= cmd_act;
        flash_addr   <= cmd_addr;
        host_offset  <= cmd_host;
        cache_offset <= cmd_cache;
        length       <= cmd_len;
        status       <= cmd_last & req_status;
        last         <= cmd_last;
        n_out        <= n_out + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n_out      <= '0;
            req_status <= 1'b0;
            off_r      <= '0;
            base_r     <= vbase + {{(32-14-fbwc_pkg::SECTOR_SHIFT){1'b0}}, sector,
                                   {fbwc_pkg::SECTOR_SHIFT{1'b0}}};
            len_r      <= {count, {fbwc_pkg::SECTOR_SHIFT{1'b0}}};
            wr_r       <= (mode == fbwc_pkg::MODE_WRITE);
            after_flush <= S_DONE;
            state      <= S_DONE;
            if (drive != 8'd0) begin
              req_status <= 1'b1;
            end else begin
              case (mode)
                fbwc_pkg::MODE_READ, fbwc_pkg::MODE_WRITE: begin
                  if (count > 7'(fbwc_pkg::MAX_SECTORS)) begin
                    req_status <= 1'b1;
                  end else if (count != 7'd0) begin
                    state <= S_CHUNK;
                  end
                end
                fbwc_pkg::MODE_SYNC: begin
                  if (flush_c) begin
                    state <= S_FE;
                  end
                end
                fbwc_pkg::MODE_MOUNT: begin
                  cache_valid <= 1'b0;
                  cache_dirty <= 1'b0;
                end
                fbwc_pkg::MODE_TRIM: begin
                  req_status <= 1'b0;
                end
                default: begin
                  req_status <= 1'b1;
                end
              endcase
            end
          end
        end
        S_CHUNK: begin
          a_r         <= a_c;
          boff_r      <= boff_c;
          chunk_r     <= chunk_c;
          hit_r       <= hit_c;
          after_flush <= full_c ? S_ER : S_LD;
          if (!wr_r) begin
            state <= S_RD;
          end else if (hit_c) begin
            state <= S_H2C;
          end else if (flush_c) begin
            state <= S_FE;
          end else begin
            state <= full_c ? S_ER : S_LD;
          end
        end
        S_FE: begin
          if (go) begin
            state <= S_FP;
          end
        end
        S_FP: begin
          if (go) begin
            cache_dirty <= 1'b0;
            state       <= after_flush;
          end
        end
        S_ER: begin
          if (go) begin
            state <= S_PH;
          end
        end
        S_LD: begin
          if (go) begin
            cached_blk  <= blk_r;
            cache_valid <= 1'b1;
            cache_dirty <= 1'b0;
            state       <= S_H2C;
          end
        end
        S_PH, S_RD, S_H2C: begin
          if (go) begin
            if (state == S_H2C) begin
              cache_dirty <= 1'b1;
            end
            off_r <= off_r + {{(LW-CW){1'b0}}, chunk_r};
            len_r <= len_r - {{(LW-CW){1'b0}}, chunk_r};
            state <= adv_state;
          end
        end
        S_DONE: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
